// File: sv/ccq_pkg.sv
// Shared types, constants and helpers for the CAN frame capture queue.
package ccq_pkg;

  localparam int RING_DEPTH        = 64;
  localparam int CHANNELS          = 2;
  localparam int MAX_PAYLOAD_BYTES = 64;
  localparam int COUNTER_WIDTH     = 32;
  localparam int WORDS             = 8;

  localparam int SLOT_W  = $clog2(RING_DEPTH);
  localparam int COUNT_W = $clog2(RING_DEPTH + 1);
  localparam int PADDR_W = $clog2(RING_DEPTH * WORDS);
  localparam int HDR_W   = 48;
  localparam int MEM_W   = HDR_W + 64;

  typedef enum logic [1:0] {
    CMD_PUSH = 2'd0, CMD_POP = 2'd1, CMD_STAT = 2'd2, CMD_NONE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_STATUS = 2'd0, KIND_WORD = 2'd1, KIND_EMPTY = 2'd2, KIND_STAT = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_ACCEPTED = 3'd0, ST_NOT_READY = 3'd1, ST_INVALID = 3'd2,
    ST_ORDER = 3'd3, ST_FULL = 3'd4
  } status_t;

  localparam logic [2:0] CNT_DRAINED = 3'd5;
  localparam logic [2:0] SEL_HIGH    = 3'd6;
  localparam logic [2:0] SEL_QUEUED  = 3'd7;

  typedef enum logic [1:0] {S_IDLE, S_COMMIT, S_POP} state_t;

  typedef struct packed {
    logic [6:0]  length;
    logic [3:0]  dlc;
    logic [3:0]  flags;
    logic [28:0] can_id;
    logic [3:0]  channel;
  } header_t;

  function automatic logic [6:0] fd_len(input logic [3:0] dlc);
    case (dlc)
      4'd9:    fd_len = 7'd12;
      4'd10:   fd_len = 7'd16;
      4'd11:   fd_len = 7'd20;
      4'd12:   fd_len = 7'd24;
      4'd13:   fd_len = 7'd32;
      4'd14:   fd_len = 7'd48;
      4'd15:   fd_len = 7'd64;
      default: fd_len = {3'd0, dlc};
    endcase
  endfunction

  function automatic logic frame_ok(input header_t h);
    logic ext, fd, brs, rtr, ok;
    ext = h.flags[0];
    fd  = h.flags[1];
    brs = h.flags[2];
    rtr = h.flags[3];
    ok = (32'(h.channel) < CHANNELS) && !rtr && (ext || h.can_id <= 29'h7ff)
         && (32'(h.length) <= MAX_PAYLOAD_BYTES);
    if (fd) ok = ok && (h.length == fd_len(h.dlc));
    else    ok = ok && !brs && (h.dlc <= 4'd8) && (h.length == {3'd0, h.dlc});
    frame_ok = ok;
  endfunction

endpackage

// File: sv/ccq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ccq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end
endmodule

// File: sv/can_frame_capture_queue.sv
// Top level of the CAN / CAN FD frame capture queue.
// Frames are pushed as 64-bit beats, the first eight of them stored; the beat
// with tlast carries the header and commits the frame. The commit is checked
// for capture gate, frame validity, timestamp order and ring room, and one
// status beat comes back. Non-final push beats return nothing. An accepted
// commit then writes the payload RAM one word per cycle (single write port),
// during which no beat is taken. A pop first reads the RAMs and then emits
// eight frame beats, one per cycle while the sink is ready; an empty ring
// gives one empty beat. Statistic reads return one beat. Header and stamp
// share one RAM, the payload another; both have registered read data, and no
// read can overlap a write since commits and pops run one at a time. Stored
// payload bytes past the frame length are zero. Counters wrap; stat_value
// shows their low 32 bits.
module can_frame_capture_queue (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // channel, can_id, frame_flags, dlc, length, stamp, data_word
  input  logic [175:0] s_tdata,
  input  logic         s_tlast,   // word_last
  // command, capture_allowed, stat_select
  input  logic [5:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // out_status, out_channel, out_can_id, out_flags, out_dlc, out_length,
  // out_stamp, out_data_word, stat_value, 5 zero pad bits
  output logic [215:0] m_tdata,
  output logic         m_tlast,   // out_last
  output logic [1:0]   m_tuser    // out_kind
);

  // input beat fields
  ccq_pkg::header_t in_hdr;
  logic [63:0]      in_ts, in_data;
  logic [1:0]       in_cmd;
  logic             in_allowed;
  logic [2:0]       in_sel;

  assign in_hdr     = ccq_pkg::header_t'(s_tdata[47:0]);
  assign in_ts      = s_tdata[111:48];
  assign in_data    = s_tdata[175:112];
  assign in_cmd     = s_tuser[1:0];
  assign in_allowed = s_tuser[2];
  assign in_sel     = s_tuser[5:3];

  // state
  ccq_pkg::state_t                  state, state_next;
  logic [ccq_pkg::SLOT_W-1:0]       read_slot, wr_slot;
  logic [ccq_pkg::COUNT_W-1:0]      entry_count, peak_count;
  logic [63:0]                      last_stamp;
  logic                             stamp_seen;
  logic [63:0]                      staging [ccq_pkg::WORDS];
  logic [3:0]                       staging_index;
  logic [ccq_pkg::COUNTER_WIDTH-1:0] counters [6];
  logic [2:0]                       word_k;
  logic [6:0]                       wr_len;

  // RAM ports
  logic                        hdr_we, hdr_re, pay_we, pay_re;
  logic [ccq_pkg::MEM_W-1:0]   hdr_wdata, hdr_rdata;
  logic [ccq_pkg::PADDR_W-1:0] pay_waddr, pay_raddr;
  logic [63:0]                 pay_wdata, pay_rdata;

  // slot for the next commit: (read_slot + entry_count) wrapped once
  logic [ccq_pkg::SLOT_W:0] slot_sum;
  logic [ccq_pkg::SLOT_W-1:0] slot_new;
  assign slot_sum = (ccq_pkg::SLOT_W+1)'(read_slot) + (ccq_pkg::SLOT_W+1)'(entry_count);
  assign slot_new = (32'(slot_sum) >= ccq_pkg::RING_DEPTH)
                  ? ccq_pkg::SLOT_W'(32'(slot_sum) - ccq_pkg::RING_DEPTH)
                  : ccq_pkg::SLOT_W'(slot_sum);

  ccq_ram #(.WIDTH(ccq_pkg::MEM_W), .DEPTH(ccq_pkg::RING_DEPTH)) u_hdr_ram (
    .clk, .we(hdr_we), .waddr(slot_new), .wdata(hdr_wdata),
    .re(hdr_re), .raddr(read_slot), .rdata(hdr_rdata)
  );

  ccq_ram #(.WIDTH(64), .DEPTH(ccq_pkg::RING_DEPTH * ccq_pkg::WORDS)) u_pay_ram (
    .clk, .we(pay_we), .waddr(pay_waddr), .wdata(pay_wdata),
    .re(pay_re), .raddr(pay_raddr), .rdata(pay_rdata)
  );

  // handshake
  logic out_free, acc, load;
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == ccq_pkg::S_IDLE) && out_free;
  assign acc      = s_tvalid && s_tready;

  // commit decision
  ccq_pkg::status_t push_status;
  logic             order_ok, full;
  assign order_ok = !stamp_seen || (in_ts >= last_stamp);
  assign full     = 32'(entry_count) >= ccq_pkg::RING_DEPTH;
  always_comb begin
    if (!in_allowed)                       push_status = ccq_pkg::ST_NOT_READY;
    else if (!ccq_pkg::frame_ok(in_hdr))   push_status = ccq_pkg::ST_INVALID;
    else if (!order_ok)                    push_status = ccq_pkg::ST_ORDER;
    else if (full)                         push_status = ccq_pkg::ST_FULL;
    else                                   push_status = ccq_pkg::ST_ACCEPTED;
  end

  logic commit_go, pop_go, pop_done;
  assign commit_go = acc && in_cmd == ccq_pkg::CMD_PUSH && s_tlast;
  assign pop_go    = acc && in_cmd == ccq_pkg::CMD_POP && entry_count != '0;
  assign pop_done  = state == ccq_pkg::S_POP && out_free && word_k == 3'd7;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ccq_pkg::S_IDLE: begin
        if (commit_go && push_status == ccq_pkg::ST_ACCEPTED) state_next = ccq_pkg::S_COMMIT;
        else if (pop_go) state_next = ccq_pkg::S_POP;
      end
      ccq_pkg::S_COMMIT: begin
        if (word_k == 3'd7) state_next = ccq_pkg::S_IDLE;
      end
      ccq_pkg::S_POP: begin
        if (pop_done) state_next = ccq_pkg::S_IDLE;
      end
      default: state_next = ccq_pkg::S_IDLE;
    endcase
  end

  // trimmed staging word for the payload write
  logic [63:0] stage_word;
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      stage_word[8*i +: 8] = ({word_k, 3'(i)} < wr_len) ? staging[word_k][8*i +: 8] : 8'd0;
    end
  end

  // statistic select
  logic [31:0] stat_sel_value;
  always_comb begin
    if (in_sel == ccq_pkg::SEL_HIGH)        stat_sel_value = 32'(peak_count);
    else if (in_sel == ccq_pkg::SEL_QUEUED) stat_sel_value = 32'(entry_count);
    else                                    stat_sel_value = 32'(counters[in_sel]);
  end

  // result beat assembly and RAM control
  logic [1:0]  o_kind;
  logic [2:0]  o_status;
  logic        o_last;
  logic [31:0] o_stat;
  logic        o_hdr_en;
  ccq_pkg::header_t pop_hdr;
  assign pop_hdr = ccq_pkg::header_t'(hdr_rdata[ccq_pkg::HDR_W-1:0]);

  always_comb begin
    load      = 1'b0;
    o_kind    = ccq_pkg::KIND_STATUS;
    o_status  = ccq_pkg::ST_ACCEPTED;
    o_last    = 1'b1;
    o_stat    = '0;
    o_hdr_en  = 1'b0;
    hdr_we    = 1'b0;
    hdr_wdata = {in_ts, in_hdr};
    hdr_re    = 1'b0;
    pay_we    = 1'b0;
    pay_waddr = {wr_slot, word_k};
    pay_wdata = stage_word;
    pay_re    = 1'b0;
    pay_raddr = {read_slot, 3'd0};
    case (state)
      ccq_pkg::S_IDLE: begin
        if (commit_go) begin
          load     = 1'b1;
          o_status = push_status;
          hdr_we   = push_status == ccq_pkg::ST_ACCEPTED;
        end else if (acc && in_cmd == ccq_pkg::CMD_POP) begin
          if (entry_count == '0) begin
            load   = 1'b1;
            o_kind = ccq_pkg::KIND_EMPTY;
          end else begin
            hdr_re = 1'b1;
            pay_re = 1'b1;
          end
        end else if (acc && in_cmd == ccq_pkg::CMD_STAT) begin
          load   = 1'b1;
          o_kind = ccq_pkg::KIND_STAT;
          o_stat = stat_sel_value;
        end
      end
      ccq_pkg::S_COMMIT: begin
        pay_we = 1'b1;
      end
      ccq_pkg::S_POP: begin
        if (out_free) begin
          load      = 1'b1;
          o_kind    = ccq_pkg::KIND_WORD;
          o_hdr_en  = 1'b1;
          o_last    = word_k == 3'd7;
          pay_re    = word_k != 3'd7;
          pay_raddr = {read_slot, word_k + 3'd1};
        end
      end
      default: ;
    endcase
  end

  // registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ccq_pkg::S_IDLE;
      read_slot     <= '0;
      entry_count   <= '0;
      peak_count    <= '0;
      last_stamp    <= '0;
      stamp_seen    <= 1'b0;
      staging_index <= '0;
      word_k        <= '0;
      m_tvalid      <= 1'b0;
      for (int i = 0; i < ccq_pkg::WORDS; i++) staging[i] <= '0;
      for (int i = 0; i < 6; i++) counters[i] <= '0;
    end else begin
      state <= state_next;
      if (load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;

      // staging clears after a rejected commit or once the payload is written
      if ((commit_go && push_status != ccq_pkg::ST_ACCEPTED) ||
          (state == ccq_pkg::S_COMMIT && word_k == 3'd7)) begin
        staging_index <= '0;
        for (int i = 0; i < ccq_pkg::WORDS; i++) staging[i] <= '0;
      end else if (acc && in_cmd == ccq_pkg::CMD_PUSH && staging_index < 4'd8) begin
        staging[staging_index[2:0]] <= in_data;
        staging_index <= staging_index + 4'd1;
      end

      if (commit_go) begin
        counters[push_status] <= counters[push_status] + 1'b1;
        if (push_status == ccq_pkg::ST_ACCEPTED || push_status == ccq_pkg::ST_FULL) begin
          stamp_seen <= 1'b1;
          last_stamp <= in_ts;
        end
        if (push_status == ccq_pkg::ST_ACCEPTED) begin
          entry_count <= entry_count + 1'b1;
          if (entry_count + 1'b1 > peak_count) peak_count <= entry_count + 1'b1;
          wr_slot <= slot_new;
          wr_len  <= in_hdr.length;
          word_k  <= '0;
        end
      end

      if (pop_go) word_k <= '0;

      if (state == ccq_pkg::S_COMMIT) begin
        word_k <= word_k + 3'd1;
      end

      if (state == ccq_pkg::S_POP && out_free) begin
        word_k <= word_k + 3'd1;
        if (pop_done) begin
          read_slot <= (32'(read_slot) == ccq_pkg::RING_DEPTH - 1) ? '0 : read_slot + 1'b1;
          entry_count <= entry_count - 1'b1;
          counters[ccq_pkg::CNT_DRAINED] <= counters[ccq_pkg::CNT_DRAINED] + 1'b1;
        end
      end
    end
  end

  // output payload register
  always_ff @(posedge clk) begin
    if (load) begin
      m_tuser <= o_kind;
      m_tlast <= o_last;
      m_tdata <= {5'd0, o_stat,
                  o_hdr_en ? pay_rdata : 64'd0,
                  o_hdr_en ? hdr_rdata[ccq_pkg::MEM_W-1:ccq_pkg::HDR_W] : 64'd0,
                  o_hdr_en ? pop_hdr : ccq_pkg::header_t'('0),
                  o_status};
    end
  end

endmodule

// File: sv/ccq_checker.sv
// Port-level checks for the capture queue, bound to the top level.
module ccq_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [215:0] m_tdata,
  input logic         m_tlast,
  input logic [1:0]   m_tuser
);
  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result beat right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result beat changed");

  a_no_take_on_stall: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !s_tready)
    else $error("input taken while result stalled");

  a_single_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == ccq_pkg::KIND_EMPTY || m_tuser == ccq_pkg::KIND_STAT
                 || m_tuser == ccq_pkg::KIND_STATUS) |-> m_tlast)
    else $error("single-beat result without last");
endmodule

bind can_frame_capture_queue ccq_checker u_ccq_checker (
  .clk, .rst, .s_tvalid, .s_tready, .m_tvalid, .m_tready, .m_tdata, .m_tlast, .m_tuser
);

// File: test/tb_top.sv
// Testbench for the CAN frame capture queue: random and directed beats checked against a predictor.
`timescale 1ns / 100ps

module tb_top;

  typedef struct {
    logic [1:0]   kind;
    logic [215:0] data;
    logic         last;
  } result_t;

  class frame_scoreboard;
    result_t   pending[$];
    ccq_pkg::header_t hdr_ram[ccq_pkg::RING_DEPTH];
    logic [63:0] stamp_ram[ccq_pkg::RING_DEPTH];
    logic [63:0] pay_ram[ccq_pkg::RING_DEPTH * ccq_pkg::WORDS];
    int unsigned rd_slot, count, hiwater;
    logic [63:0] last_ts;
    bit          ts_seen;
    logic [63:0] stage[ccq_pkg::WORDS];
    int unsigned stage_idx;
    logic [31:0] events[6];
    int          errors;

    function new();
      rd_slot = 0; count = 0; hiwater = 0; last_ts = 0; ts_seen = 0;
      stage_idx = 0; errors = 0;
      foreach (stage[i]) stage[i] = '0;
      foreach (events[i]) events[i] = '0;
    endfunction

    function void push_result(logic [1:0] kind, logic [215:0] data, logic last);
      result_t r;
      r.kind = kind; r.data = data; r.last = last;
      pending.push_back(r);
    endfunction

    function logic [6:0] fd_bytes(logic [3:0] d);
      logic [6:0] t[16];
      t = '{0, 1, 2, 3, 4, 5, 6, 7, 8, 12, 16, 20, 24, 32, 48, 64};
      return t[d];
    endfunction

    function bit valid_frame(ccq_pkg::header_t h);
      if (h.channel >= ccq_pkg::CHANNELS || h.flags[3]) return 0;
      if (!h.flags[0] && h.can_id > 29'h7ff) return 0;
      if (h.length > ccq_pkg::MAX_PAYLOAD_BYTES) return 0;
      if (h.flags[1]) return h.length == fd_bytes(h.dlc);
      return !h.flags[2] && h.dlc <= 8 && h.length == {3'd0, h.dlc};
    endfunction

    function ccq_pkg::status_t commit_frame(bit allowed, ccq_pkg::header_t h, logic [63:0] ts);
      int unsigned slot;
      int unsigned lim;
      if (!allowed) begin
        events[ccq_pkg::ST_NOT_READY]++; return ccq_pkg::ST_NOT_READY;
      end
      if (!valid_frame(h)) begin
        events[ccq_pkg::ST_INVALID]++; return ccq_pkg::ST_INVALID;
      end
      if (ts_seen && ts < last_ts) begin
        events[ccq_pkg::ST_ORDER]++; return ccq_pkg::ST_ORDER;
      end
      ts_seen = 1; last_ts = ts;
      if (count >= ccq_pkg::RING_DEPTH) begin
        events[ccq_pkg::ST_FULL]++; return ccq_pkg::ST_FULL;
      end
      slot = (rd_slot + count) % ccq_pkg::RING_DEPTH;
      hdr_ram[slot] = h; stamp_ram[slot] = ts;
      for (int k = 0; k < ccq_pkg::WORDS; k++) begin
        // zero the bytes past the frame length
        lim = 32'(h.length);
        pay_ram[slot * ccq_pkg::WORDS + k] = stage[k];
        for (int b = 0; b < 8; b++)
          if (k * 8 + b >= lim) pay_ram[slot * ccq_pkg::WORDS + k][b*8 +: 8] = 8'h00;
      end
      count++; events[ccq_pkg::ST_ACCEPTED]++;
      if (count > hiwater) hiwater = count;
      return ccq_pkg::ST_ACCEPTED;
    endfunction

    // Note one accepted input beat and queue what it should produce.
    function void note_input(logic [175:0] d, logic last, logic [5:0] u);
      ccq_pkg::cmd_t    cmd;
      ccq_pkg::header_t h;
      ccq_pkg::status_t st;
      logic [31:0]  v;
      logic [215:0] o;
      logic [2:0]   sel;
      cmd = ccq_pkg::cmd_t'(u[1:0]);
      sel = u[5:3];
      h = '{length: d[47:41], dlc: d[40:37], flags: d[36:33], can_id: d[32:4],
            channel: d[3:0]};
      case (cmd)
        ccq_pkg::CMD_PUSH: begin
          if (stage_idx < ccq_pkg::WORDS) begin
            stage[stage_idx] = d[175:112]; stage_idx++;
          end
          if (last) begin
            st = commit_frame(u[2], h, d[111:48]);
            o = '0; o[2:0] = st;
            push_result(ccq_pkg::KIND_STATUS, o, 1'b1);
            foreach (stage[i]) stage[i] = '0;
            stage_idx = 0;
          end
        end
        ccq_pkg::CMD_POP: begin
          if (count == 0) push_result(ccq_pkg::KIND_EMPTY, '0, 1'b1);
          else begin
            for (int k = 0; k < ccq_pkg::WORDS; k++) begin
              o = '0;
              o[50:3]    = hdr_ram[rd_slot];
              o[114:51]  = stamp_ram[rd_slot];
              o[178:115] = pay_ram[rd_slot * ccq_pkg::WORDS + k];
              push_result(ccq_pkg::KIND_WORD, o, k == ccq_pkg::WORDS - 1);
            end
            rd_slot = (rd_slot + 1) % ccq_pkg::RING_DEPTH;
            count--; events[ccq_pkg::CNT_DRAINED]++;
          end
        end
        ccq_pkg::CMD_STAT: begin
          if (sel < ccq_pkg::SEL_HIGH) v = events[sel];
          else if (sel == ccq_pkg::SEL_HIGH) v = hiwater;
          else v = count;
          o = '0; o[210:179] = v;
          push_result(ccq_pkg::KIND_STAT, o, 1'b1);
        end
        default: ;
      endcase
    endfunction

    // Compare one result beat with the oldest expectation.
    function void check_result(logic [1:0] kind, logic [215:0] d, logic last);
      result_t e;
      if (pending.size() == 0) begin
        $error("unexpected result beat kind=%0d", kind);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (kind !== e.kind) begin
        $error("out_kind exp %0d got %0d", e.kind, kind); errors++; end
      if (last !== e.last) begin
        $error("out_last exp %0d got %0d", e.last, last); errors++; end
      if (d[2:0] !== e.data[2:0]) begin
        $error("out_status exp %0d got %0d", e.data[2:0], d[2:0]); errors++; end
      if (d[6:3] !== e.data[6:3]) begin
        $error("out_channel exp %0d got %0d", e.data[6:3], d[6:3]); errors++; end
      if (d[35:7] !== e.data[35:7]) begin
        $error("out_can_id exp %h got %h", e.data[35:7], d[35:7]); errors++; end
      if (d[39:36] !== e.data[39:36]) begin
        $error("out_flags exp %h got %h", e.data[39:36], d[39:36]); errors++; end
      if (d[43:40] !== e.data[43:40]) begin
        $error("out_dlc exp %0d got %0d", e.data[43:40], d[43:40]); errors++; end
      if (d[50:44] !== e.data[50:44]) begin
        $error("out_length exp %0d got %0d", e.data[50:44], d[50:44]); errors++; end
      if (d[114:51] !== e.data[114:51]) begin
        $error("out_stamp exp %h got %h", e.data[114:51], d[114:51]); errors++; end
      if (d[178:115] !== e.data[178:115]) begin
        $error("out_data_word exp %h got %h", e.data[178:115], d[178:115]); errors++; end
      if (d[210:179] !== e.data[210:179]) begin
        $error("stat_value exp %h got %h", e.data[210:179], d[210:179]); errors++; end
    endfunction
  endclass

  logic         clk = 0;
  logic         rst = 1;
  logic         s_tvalid = 0;
  logic         s_tready;
  logic [175:0] s_tdata = '0;
  logic         s_tlast = 0;
  logic [5:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 0;
  logic [215:0] m_tdata;
  logic         m_tlast;
  logic [1:0]   m_tuser;

  frame_scoreboard sb = new();
  int  send_idle_pct = 0;   // chance in percent that the sender idles a cycle
  int  recv_stall_pct = 0;  // chance in percent that the sink stalls a cycle
  longint cycles = 0;
  logic [63:0] clock_us = 64'd1000;  // running stamp for well-formed frames

  always #5 clk = ~clk;

  can_frame_capture_queue u_top (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 64'd1_000_000) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Sink side: random stalls, check each accepted beat.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tuser, m_tdata, m_tlast);
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Drive one input beat, with optional idle cycles first; return when it is taken.
  // tvalid stays high after the take; idle cycles and wait_drain drop it.
  task automatic send_beat(logic [1:0] cmd, bit allowed, logic [2:0] sel,
                           ccq_pkg::header_t h, logic [63:0] ts, logic [63:0] word,
                           bit last);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 0;
      @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata  <= {word, ts, h[47:0]};
    s_tlast  <= last;
    s_tuser  <= {sel, allowed, cmd};
    do @(posedge clk); while (!s_tready);
    sb.note_input({word, ts, h[47:0]}, last, {sel, allowed, cmd});
  endtask

  function automatic ccq_pkg::header_t good_header();
    ccq_pkg::header_t h;
    logic [6:0] fdl[16];
    fdl = '{0, 1, 2, 3, 4, 5, 6, 7, 8, 12, 16, 20, 24, 32, 48, 64};
    h.channel = 4'($urandom_range(ccq_pkg::CHANNELS - 1));
    h.flags = 4'($urandom_range(3));
    if ($urandom_range(1) != 0 && h.flags[1]) h.flags[2] = 1'b1;
    h.can_id = h.flags[0] ? 29'($urandom) : 29'($urandom_range(11'h7ff));
    if (h.flags[1]) begin h.dlc = 4'($urandom); h.length = fdl[h.dlc]; end
    else begin h.dlc = 4'($urandom_range(8)); h.length = {3'd0, h.dlc}; end
    return h;
  endfunction

  function automatic ccq_pkg::header_t any_header();
    ccq_pkg::header_t h;
    h = 48'({$urandom, $urandom});
    return h;
  endfunction

  task automatic push_frame(ccq_pkg::header_t h, bit allowed, logic [63:0] ts, int nwords);
    for (int i = 0; i < nwords; i++)
      send_beat(ccq_pkg::CMD_PUSH, allowed, 3'($urandom), h, ts, {$urandom, $urandom},
                i == nwords - 1);
  endtask

  task automatic pop_frame();
    send_beat(ccq_pkg::CMD_POP, 1'($urandom), 3'($urandom), any_header(),
              {$urandom, $urandom}, {$urandom, $urandom}, 1'($urandom));
  endtask

  task automatic read_stat(logic [2:0] sel);
    send_beat(ccq_pkg::CMD_STAT, 1'($urandom), sel, any_header(), {$urandom, $urandom},
              {$urandom, $urandom}, 1'($urandom));
  endtask

  task automatic random_item();
    int r;
    ccq_pkg::header_t h;
    r = $urandom_range(99);
    if (r < 45) begin
      clock_us += $urandom_range(500);
      push_frame(good_header(), $urandom_range(9) != 0, clock_us, $urandom_range(1, 10));
    end else if (r < 55) begin
      h = any_header();
      push_frame(h, 1'($urandom), {$urandom, $urandom}, $urandom_range(1, 9));
    end else if (r < 80) pop_frame();
    else if (r < 95) read_stat(3'($urandom));
    else send_beat(ccq_pkg::CMD_NONE, 1'($urandom), 3'($urandom), any_header(),
                   {$urandom, $urandom}, {$urandom, $urandom}, 1'($urandom));
  endtask

  task automatic wait_drain();
    s_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  initial begin
    ccq_pkg::header_t h;
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: empty pop, every status but full, extremes, all stats
    pop_frame();
    h = '{length: 64, dlc: 15, flags: 4'b0111, can_id: 29'h1fffffff, channel: 1};
    push_frame(h, 1, 64'd100, 8);
    h = '{length: 0, dlc: 0, flags: 0, can_id: 0, channel: 0};
    push_frame(h, 1, 64'd100, 1);                 // equal stamp is in order
    push_frame(h, 0, 64'd200, 2);                 // gate closed
    h.flags = 4'b1000; push_frame(h, 1, 64'd200, 1);  // remote
    h = '{length: 8, dlc: 8, flags: 4'b0100, can_id: 29'h7ff, channel: 0};
    push_frame(h, 1, 64'd200, 1);                 // brs on classic
    h.flags = 0; h.can_id = 29'h800; push_frame(h, 1, 64'd200, 1);  // std id too big
    h.can_id = 5; h.channel = 15; push_frame(h, 1, 64'd200, 1);
    h.channel = 1; h.length = 127; push_frame(h, 1, 64'd200, 1);
    h.length = 8; push_frame(h, 1, 64'd50, 1);    // out of order
    h = '{length: 3, dlc: 3, flags: 0, can_id: 7, channel: 1};
    push_frame(h, 1, 64'hffffffffffffffff, 10);   // staging overflow, max stamp
    for (int s = 0; s < 8; s++) read_stat(3'(s));
    pop_frame(); pop_frame(); pop_frame(); pop_frame();
    wait_drain();
    clock_us = 0;

    // fill past full; stamp still tracked on full drops
    sb.ts_seen = sb.ts_seen;
    begin
      int n;
      n = 0;
      while (n < 70) begin
        h = good_header(); clock_us += 1;
        // the earlier max stamp blocks order; rebase by reset-free trick: use max
        push_frame(h, 1, 64'hffffffffffffffff, 1);
        n++;
      end
    end
    read_stat(ccq_pkg::SEL_HIGH); read_stat(ccq_pkg::SEL_QUEUED);
    read_stat(3'(ccq_pkg::ST_FULL));
    repeat (66) pop_frame();
    wait_drain();

    // since stamps are pinned at max, random pushes use max stamps via offset
    clock_us = 64'hffffffffffffffff;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
        default: begin send_idle_pct = 16; recv_stall_pct = 16; end
      endcase
      for (int i = 0; i < 14; i++) begin
        if ($urandom_range(3) == 0) clock_us = 64'hffffffffffffffff - $urandom_range(3);
        random_item();
        if (clock_us < 64'hfffffffffffffe00) clock_us = 64'hffffffffffffffff;
      end
      wait_drain();
    end

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule

// File: files.f
sv/ccq_pkg.sv
sv/ccq_ram.sv
sv/can_frame_capture_queue.sv
sv/ccq_checker.sv
test/tb_top.sv
